### rtl/core/grouped_reduce_sum_mean_argmax_defines.svh
// Assertion macros for the grouped reduction block.
// Included by the top level; no other dependencies.
`ifndef GROUPED_REDUCE_SUM_MEAN_ARGMAX_DEFINES_SVH
`define GROUPED_REDUCE_SUM_MEAN_ARGMAX_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define GRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/grs_pkg.sv
// Shared types and constants of the grouped reduction block.
// No dependencies; imported by every module of the block.
package grs_pkg;

  localparam int VAL_W      = 32;
  localparam int SUM_W      = 52;
  localparam int IDX_W      = 20;
  localparam int GRP_W      = 16;
  localparam int DIV_W      = 21;
  localparam int INDEX_BITS = 20;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int DCNT_W     = $clog2(SUM_W);

  // Index bits kept from element_index.
  localparam logic [IDX_W-1:0] IDX_MASK =
    (INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] OUT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] OUT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_MEAN = 2'd0,
    MODE_SUM  = 2'd1,
    MODE_MAX  = 2'd2,
    MODE_MIN  = 2'd3
  } mode_t;

  // Register select, taken from paddr[2].
  typedef enum logic {
    REG_MODE = 1'b0,
    REG_DIV  = 1'b1
  } reg_sel_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIX,
    BK_EMIT
  } back_state_t;

  // One finished group, front to back.
  typedef struct packed {
    logic [GRP_W-1:0]        grp;
    mode_t                   mode;
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] best;
    logic [IDX_W-1:0]        idx;
  } grs_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } grs_q_stat_t;

endpackage

### rtl/core/grs_front.sv
// Front end: accepts samples, keeps the running sum and best value per group,
// and pushes one record per finished group. Depends on grs_pkg.
module grs_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             in_sample_value,
  input  logic [19:0]                    in_element_index,
  input  logic                           in_group_last,
  input  grs_pkg::mode_t                 cfg_mode,
  input  grs_pkg::grs_q_stat_t           q_stat,
  output logic                           q_push,
  output grs_pkg::grs_rec_t              q_wr
);
  import grs_pkg::*;

  logic                    open_r, open_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]        bidx_r, bidx_nxt;
  logic [GRP_W-1:0]        gcnt_r, gcnt_nxt;

  logic                    accept;
  logic signed [SUM_W-1:0] v_ext;
  logic signed [SUM_W:0]   add;
  logic signed [SUM_W-1:0] sat_sum, new_sum;
  logic signed [VAL_W-1:0] new_best;
  logic [IDX_W-1:0]        idx_kept, new_idx;
  logic                    better;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    v_ext    = {{(SUM_W-VAL_W){in_sample_value[VAL_W-1]}}, in_sample_value};
    idx_kept = in_element_index & IDX_MASK;
    add      = {sum_r[SUM_W-1], sum_r} + {v_ext[SUM_W-1], v_ext};
    if (add[SUM_W] != add[SUM_W-1]) begin
      sat_sum = add[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_sum = add[SUM_W-1:0];
    end
    if (cfg_mode == MODE_MIN) begin
      better = in_sample_value < best_r;
    end else begin
      better = in_sample_value > best_r;
    end
    if (!open_r) begin
      new_sum  = v_ext;
      new_best = in_sample_value;
      new_idx  = idx_kept;
    end else begin
      new_sum  = sat_sum;
      new_best = better ? in_sample_value : best_r;
      new_idx  = better ? idx_kept : bidx_r;
    end
  end

  always_comb begin
    q_push    = accept && in_group_last;
    q_wr.grp  = gcnt_r;
    q_wr.mode = cfg_mode;
    q_wr.sum  = new_sum;
    q_wr.best = new_best;
    q_wr.idx  = new_idx;
  end

  always_comb begin
    open_nxt = open_r;
    sum_nxt  = sum_r;
    best_nxt = best_r;
    bidx_nxt = bidx_r;
    gcnt_nxt = gcnt_r;
    if (accept) begin
      if (in_group_last) begin
        // Close the group and start clean.
        open_nxt = 1'b0;
        sum_nxt  = '0;
        best_nxt = '0;
        bidx_nxt = '0;
        gcnt_nxt = gcnt_r + 1'b1;
      end else begin
        open_nxt = 1'b1;
        sum_nxt  = new_sum;
        best_nxt = new_best;
        bidx_nxt = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      sum_r  <= '0;
      best_r <= '0;
      bidx_r <= '0;
      gcnt_r <= '0;
    end else begin
      open_r <= open_nxt;
      sum_r  <= sum_nxt;
      best_r <= best_nxt;
      bidx_r <= bidx_nxt;
      gcnt_r <= gcnt_nxt;
    end
  end

endmodule

### rtl/core/grs_queue.sv
// Short record queue between front and back end.
// Depends on grs_pkg.
module grs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  grs_pkg::grs_rec_t    wr_data,
  input  logic                 pop,
  output grs_pkg::grs_rec_t    rd_data,
  output grs_pkg::grs_q_stat_t stat
);
  import grs_pkg::*;

  grs_rec_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/core/grs_back.sv
// Back end: pops group records, divides for the mean one quotient bit per
// cycle, saturates, and holds the result beat. Depends on grs_pkg.
module grs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [20:0]                cfg_divisor,
  input  grs_pkg::grs_q_stat_t       q_stat,
  input  grs_pkg::grs_rec_t          q_rd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_group_number,
  output logic signed [31:0]         out_reduced_value,
  output logic [19:0]                out_winner_index
);
  import grs_pkg::*;

  back_state_t             state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [GRP_W-1:0]        out_grp_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [IDX_W-1:0]        out_idx_r;

  logic [GRP_W-1:0]        grp_r;
  logic signed [VAL_W-1:0] res_val_r;
  logic [IDX_W-1:0]        res_idx_r;
  logic                    neg_r;
  logic [SUM_W-1:0]        quo_r;
  logic [DIV_W-1:0]        rem_r;
  logic [DIV_W-1:0]        div_r;
  logic [DCNT_W-1:0]       dcnt_r;

  logic                    out_load;
  logic [DIV_W:0]          rem_sh;
  logic                    ge;
  logic signed [VAL_W-1:0] sum_sat;
  logic [SUM_W-1:0]        mag;
  logic signed [VAL_W-1:0] mean_val;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (q_rd.mode == MODE_MEAN) ? BK_DIV : BK_EMIT;
        end
      end
      BK_DIV:  state_nxt = (dcnt_r == '0) ? BK_FIX : BK_DIV;
      BK_FIX:  state_nxt = BK_EMIT;
      BK_EMIT: state_nxt = out_load ? BK_IDLE : BK_EMIT;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop    = !q_stat.empty;
      BK_EMIT: out_load = !out_valid_r || !out_stall;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    // Saturate the 52-bit sum to 32 bits.
    if (q_rd.sum[SUM_W-1:VAL_W-1] != {(SUM_W-VAL_W+1){q_rd.sum[SUM_W-1]}}) begin
      sum_sat = q_rd.sum[SUM_W-1] ? OUT_MIN : OUT_MAX;
    end else begin
      sum_sat = q_rd.sum[VAL_W-1:0];
    end
    mag = q_rd.sum[SUM_W-1] ? SUM_W'(-q_rd.sum) : SUM_W'(q_rd.sum);

    rem_sh = {rem_r, quo_r[SUM_W-1]};
    ge     = rem_sh >= {1'b0, div_r};

    if (neg_r) begin
      mean_val = (quo_r > SUM_W'({1'b0, OUT_MIN})) ? OUT_MIN : VAL_W'(-quo_r);
    end else begin
      mean_val = (quo_r > SUM_W'(OUT_MAX)) ? OUT_MAX : VAL_W'(quo_r);
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        grp_r  <= q_rd.grp;
        neg_r  <= q_rd.sum[SUM_W-1];
        quo_r  <= mag;
        rem_r  <= '0;
        div_r  <= (cfg_divisor == '0) ? DIV_W'(1) : cfg_divisor;
        dcnt_r <= DCNT_W'(SUM_W - 1);
        if (q_rd.mode == MODE_MAX || q_rd.mode == MODE_MIN) begin
          res_val_r <= q_rd.best;
          res_idx_r <= q_rd.idx;
        end else begin
          res_val_r <= sum_sat;
          res_idx_r <= '0;
        end
      end
      BK_DIV: begin
        // One restoring step: shift in the next dividend bit, subtract if it fits.
        rem_r  <= ge ? DIV_W'(rem_sh - {1'b0, div_r}) : DIV_W'(rem_sh);
        quo_r  <= {quo_r[SUM_W-2:0], ge};
        dcnt_r <= dcnt_r - 1'b1;
      end
      BK_FIX: res_val_r <= mean_val;
      default: begin
        res_val_r <= res_val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_grp_r <= grp_r;
      out_val_r <= res_val_r;
      out_idx_r <= res_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_group_number  = out_grp_r;
  assign out_reduced_value = out_val_r;
  assign out_winner_index  = out_idx_r;

endmodule

### rtl/core/grouped_reduce_sum_mean_argmax.sv
// Top level of the grouped reduction block: config registers, front end,
// record queue and back end. Depends on grs_pkg, grs_front, grs_queue, grs_back.
//
//   Channel  Ports                                        Beat moves when
//   in       in_valid/in_stall, sample, index, last       valid && !stall
//   out      out_valid/out_stall, group, value, winner    valid && !stall
//   cfg      psel/penable/pwrite/paddr/pwdata/prdata      psel && penable && pwrite
//
// Flow: the front takes one sample per cycle while in_stall is low. Each
// finished group goes to a four-entry queue; the back end takes one group at a
// time: it pops and sets up, runs 52 restoring steps of the divider and a
// fix-up for a mean group, and ends with the output load, so short groups can
// throttle the input via the queue.
// Reset: rst_n is synchronous, active low; mode resets to sum, divisor to 1.
// Stalls: in_stall rises only when the queue is full; the output register
// holds its beat under out_stall while the back end works on the next group.
`include "grouped_reduce_sum_mean_argmax_defines.svh"

module grouped_reduce_sum_mean_argmax (
  input  logic               clk,
  input  logic               rst_n,
  // Sample stream
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sample_value,
  input  logic [19:0]        in_element_index,
  input  logic               in_group_last,
  // Result stream
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_group_number,
  output logic signed [31:0] out_reduced_value,
  output logic [19:0]        out_winner_index,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import grs_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [DIV_W-1:0] div_r, div_nxt;
  reg_sel_t         sel;
  logic             cfg_wr;

  logic             q_push;
  logic             q_pop;
  grs_rec_t         q_wr;
  grs_rec_t         q_rd;
  grs_q_stat_t      q_stat;

  // Register file: decode on address bit 2, ignore byte offset.
  assign pready = 1'b1;
  assign sel    = reg_sel_t'(paddr[2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    mode_nxt = mode_r;
    div_nxt  = div_r;
    if (cfg_wr) begin
      unique case (sel)
        REG_MODE: mode_nxt = mode_t'(pwdata[1:0]);
        REG_DIV:  div_nxt  = pwdata[DIV_W-1:0];
        default:  mode_nxt = mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_MODE: prdata = {30'd0, mode_r};
      REG_DIV:  prdata = {{(32-DIV_W){1'b0}}, div_r};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SUM;
      div_r  <= DIV_W'(1);
    end else begin
      mode_r <= mode_nxt;
      div_r  <= div_nxt;
    end
  end

  // Accumulate per sample, emit one record per group.
  grs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .in_element_index (in_element_index),
    .in_group_last    (in_group_last),
    .cfg_mode         (mode_r),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_wr             (q_wr)
  );

  // Decouple the per-sample front from the slow mean path.
  grs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  // Finish each group: divide, saturate, drive the result beat.
  grs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_divisor       (div_r),
    .q_stat            (q_stat),
    .q_rd              (q_rd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_group_number  (out_group_number),
    .out_reduced_value (out_reduced_value),
    .out_winner_index  (out_winner_index)
  );

  // Never push into a full queue or pop an empty one.
  `GRS_ASSERT_IMPL(a_push_not_full, clk, rst_n, q_push, !q_stat.full, "push into full queue")
  `GRS_ASSERT_IMPL(a_pop_not_empty, clk, rst_n, q_pop, !q_stat.empty, "pop from empty queue")
  // A full queue must hold back the input.
  `GRS_ASSERT_IMPL(a_full_stalls, clk, rst_n, q_stat.full, in_stall, "full queue without stall")

endmodule
